@@ sv/onpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onpa_pkg
// shared types and constants of the omega network path allocator
// ----------------------------------------------------------------------------
package onpa_pkg;

  localparam int PortsDef      = 256;
  localparam int MaxColumnsDef = 6;

  localparam int PortW   = 8;
  localparam int WordW   = 20;
  localparam int StagesW = 3;
  localparam int ExtraW  = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STAGES    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXTRA     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PORT_MASK = 2'd2;

  // request function codes
  localparam logic FUNC_ROUTE   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef struct packed {
    logic             func;
    logic [PortW-1:0] source_port;
    logic [PortW-1:0] dest_port;
    logic [WordW-1:0] release_word;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [WordW-1:0] path_word;
  } rsp_t;

  // effective network geometry, clamped
  typedef struct packed {
    logic [StagesW-1:0] stages;
    logic [ExtraW-1:0]  extra;
    logic [PortW-1:0]   port_mask;
  } geom_t;

endpackage

@@ sv/onpa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onpa_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module onpa_ram #(
  parameter int Width = 3,
  parameter int Depth = 1536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/onpa_addr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onpa_addr
// switch address and setting of one stage column of a path word
// ----------------------------------------------------------------------------
module onpa_addr #(
  parameter int Ports      = onpa_pkg::PortsDef,
  parameter int MaxColumns = onpa_pkg::MaxColumnsDef,
  localparam int ColW      = (MaxColumns > 1) ? $clog2(MaxColumns) : 1,
  localparam int AddrW     = $clog2(Ports * MaxColumns)
) (
  input  onpa_pkg::geom_t               geom_i,
  input  logic [onpa_pkg::WordW-1:0]    word_i,
  input  logic [ColW-1:0]               col_i,
  output logic [AddrW-1:0]              addr_o,
  output logic [1:0]                    setting_o
);

  localparam int IdxW = $clog2(Ports);

  logic [IdxW-1:0]             mod_lut [256];
  logic [2:0]                  idx_digit;
  logic [3:0]                  idx_sh;
  logic [onpa_pkg::WordW-1:0]  idx_win;
  logic [onpa_pkg::PortW-1:0]  idx_raw;
  logic [IdxW-1:0]             idx_mod;
  logic [3:0]                  set_digit;
  logic [4:0]                  set_sh;
  logic [onpa_pkg::WordW-1:0]  set_win;

  // switch index modulo port count
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_lut[g] = IdxW'(g % Ports);
  end

  // index window sits at digit cols-1-col
  assign idx_digit = 3'(geom_i.stages) + 3'(geom_i.extra) - 3'd1 - 3'(col_i);
  assign idx_sh    = {idx_digit, 1'b0};
  assign idx_win   = word_i >> idx_sh;
  assign idx_raw   = idx_win[onpa_pkg::PortW-1:0] & geom_i.port_mask;
  assign idx_mod   = mod_lut[idx_raw];
  assign addr_o    = AddrW'(idx_mod) * AddrW'(MaxColumns) + AddrW'(col_i);

  // setting digit sits at 2s+e-1-col
  assign set_digit = {1'b0, geom_i.stages} + {1'b0, geom_i.stages} + 4'(geom_i.extra)
                     - 4'd1 - 4'(col_i);
  assign set_sh    = {set_digit, 1'b0};
  assign set_win   = word_i >> set_sh;
  assign setting_o = set_win[1:0];

endmodule

@@ sv/omega_network_path_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omega_network_path_allocator
// circuit allocator for a radix-4 omega network with extra stages
// ----------------------------------------------------------------------------
// usage
//   a request beat is taken when start_i is high and busy_o is low. req_i.func
//   selects a route request (source and dest port) or a release of a path
//   word. the result beat shows on rsp_o for one cycle with done_o high; the
//   receiver cannot stall it. a new request may start in the done cycle.
//   registers (stages, extra_stages, port_mask) are written through cfg_we_i;
//   the user must write them only while idle, the block does not enforce it.
// operation, with n = min(stages + extra_stages, MAX_COLUMNS) columns and
// t = 4^extra_stages candidate words
//   route:   up to t candidate words of n columns each; switch table reads stream one column
//            per cycle through the single ram read port, the first free word
//            is then written back one column per cycle
//   release: one write per column
//   zero columns: result in the cycle after the start beat
// reset
//   busy_o stays high while all PORTS*MAX_COLUMNS (1536 at default) entries of
//   the switch table are swept clear; register writes are taken meanwhile
// ----------------------------------------------------------------------------
module omega_network_path_allocator #(
  parameter int PORTS       = onpa_pkg::PortsDef,
  parameter int MAX_COLUMNS = onpa_pkg::MaxColumnsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  onpa_pkg::req_t                req_i,
  output logic                          done_o,
  output onpa_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [onpa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [onpa_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int ColW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int Depth = PORTS * MAX_COLUMNS;
  localparam int AddrW = $clog2(Depth);
  localparam int WordW = onpa_pkg::WordW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RELEASE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [onpa_pkg::StagesW-1:0] stages_q;
  logic [onpa_pkg::ExtraW-1:0]  extra_q;
  logic [onpa_pkg::PortW-1:0]   mask_q;

  // request and scan state
  logic [onpa_pkg::PortW-1:0]   src_q;
  logic [onpa_pkg::PortW-1:0]   dst_q;
  logic [WordW-1:0]             word_q;
  logic [3:0]                   x_q;
  logic [ColW-1:0]              col_q;
  logic                         issue_on_q;
  logic                         ok_q;
  logic                         chk_vld_q;
  logic                         chk_last_q;
  logic                         chk_xlast_q;
  logic [WordW-1:0]             chk_word_q;
  logic [1:0]                   chk_set_q;
  logic [AddrW-1:0]             clr_q;
  logic                         done_q;
  onpa_pkg::rsp_t               rsp_q;

  onpa_pkg::geom_t              geom;
  logic [2:0]                   ncol;
  logic                         col_last;
  logic                         x_last;
  logic [3:0]                   x_max;
  logic [3:0]                   sh_x;
  logic [3:0]                   sh_src;
  logic [WordW-1:0]             word_x;
  logic [WordW-1:0]             word_req;
  logic [WordW-1:0]             word_sel;
  logic [AddrW-1:0]             col_addr;
  logic [1:0]                   col_set;
  logic                         conflict;
  logic                         scan_hit;

  // ram ports
  logic                         ram_we;
  logic [AddrW-1:0]             ram_waddr;
  logic [2:0]                   ram_wdata;
  logic                         ram_re;
  logic [2:0]                   ram_rdata;

  // clamped geometry
  assign geom.stages    = (stages_q > 3'd4) ? 3'd4 : stages_q;
  assign geom.extra     = (extra_q > 2'd2) ? 2'd2 : extra_q;
  assign geom.port_mask = mask_q;

  // columns kept in the table
  always_comb begin
    ncol = 3'(geom.stages) + 3'(geom.extra);
    if (ncol > 3'(MAX_COLUMNS)) begin
      ncol = 3'(MAX_COLUMNS);
    end
  end

  assign col_last = (3'(col_q) == ncol - 3'd1);
  assign x_max    = 4'((5'd1 << {geom.extra, 1'b0}) - 5'd1);
  assign x_last   = (x_q == x_max);

  // candidate word: dest | extra digits | source
  assign sh_x     = {1'b0, geom.stages} + {1'b0, geom.stages};
  assign sh_src   = sh_x + {1'b0, geom.extra, 1'b0};
  assign word_x   = WordW'(dst_q) | (WordW'(src_q) << sh_src) | (WordW'(x_q) << sh_x);
  assign word_req = WordW'(req_i.dest_port) | (WordW'(req_i.source_port) << sh_src);
  assign word_sel = (state_q == ST_SCAN) ? word_x : word_q;

  onpa_addr #(
    .Ports      (PORTS),
    .MaxColumns (MAX_COLUMNS)
  ) u_addr (
    .geom_i    (geom),
    .word_i    (word_sel),
    .col_i     (col_q),
    .addr_o    (col_addr),
    .setting_o (col_set)
  );

  // entry is {busy, setting}
  assign conflict = ram_rdata[2] && (ram_rdata[1:0] != chk_set_q);

  // last column of a candidate checked with no conflict anywhere
  assign scan_hit = chk_vld_q && chk_last_q && ok_q && !conflict;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col_addr;
    ram_wdata = 3'b000;
    ram_re    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      ST_SCAN: begin
        ram_re = issue_on_q;
      end
      ST_COMMIT: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, col_set};
      end
      ST_RELEASE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  onpa_ram #(
    .Width (3),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (col_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      stages_q    <= 3'd4;
      extra_q     <= 2'd0;
      mask_q      <= 8'd255;
      src_q       <= '0;
      dst_q       <= '0;
      word_q      <= '0;
      x_q         <= '0;
      col_q       <= '0;
      issue_on_q  <= 1'b0;
      ok_q        <= 1'b0;
      chk_vld_q   <= 1'b0;
      chk_last_q  <= 1'b0;
      chk_xlast_q <= 1'b0;
      chk_word_q  <= '0;
      chk_set_q   <= '0;
      clr_q       <= '0;
      done_q      <= 1'b0;
      rsp_q       <= '0;
    end else begin
      done_q <= 1'b0;

      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          onpa_pkg::CFG_STAGES:    stages_q <= cfg_data_i[onpa_pkg::StagesW-1:0];
          onpa_pkg::CFG_EXTRA:     extra_q  <= cfg_data_i[onpa_pkg::ExtraW-1:0];
          onpa_pkg::CFG_PORT_MASK: mask_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end

      case (state_q)
        // sweep the switch table after reset
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(Depth - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (start_i) begin
            src_q      <= req_i.source_port;
            dst_q      <= req_i.dest_port;
            word_q     <= req_i.release_word;
            x_q        <= '0;
            col_q      <= '0;
            ok_q       <= 1'b1;
            chk_vld_q  <= 1'b0;
            if (ncol == 3'd0) begin
              // no columns: nothing to touch
              done_q          <= 1'b1;
              rsp_q.granted   <= 1'b1;
              rsp_q.path_word <= (req_i.func == onpa_pkg::FUNC_RELEASE) ? '0 : word_req;
            end else if (req_i.func == onpa_pkg::FUNC_RELEASE) begin
              state_q <= ST_RELEASE;
            end else begin
              state_q    <= ST_SCAN;
              issue_on_q <= 1'b1;
            end
          end
        end

        ST_SCAN: begin
          if (scan_hit) begin
            // first free word found, drop the reads still in flight
            state_q    <= ST_COMMIT;
            word_q     <= chk_word_q;
            col_q      <= '0;
            issue_on_q <= 1'b0;
            chk_vld_q  <= 1'b0;
          end else begin
            // issue one column read per cycle
            chk_vld_q <= issue_on_q;
            if (issue_on_q) begin
              chk_last_q  <= col_last;
              chk_xlast_q <= x_last;
              chk_word_q  <= word_x;
              chk_set_q   <= col_set;
              if (col_last) begin
                col_q <= '0;
                if (x_last) begin
                  issue_on_q <= 1'b0;
                end else begin
                  x_q <= x_q + 4'd1;
                end
              end else begin
                col_q <= col_q + 1'b1;
              end
            end
            // check the column read issued in the cycle before
            if (chk_vld_q) begin
              if (chk_last_q) begin
                if (chk_xlast_q) begin
                  state_q         <= ST_IDLE;
                  done_q          <= 1'b1;
                  rsp_q.granted   <= 1'b0;
                  rsp_q.path_word <= '0;
                end else begin
                  ok_q <= 1'b1;
                end
              end else begin
                ok_q <= ok_q && !conflict;
              end
            end
          end
        end

        // mark switches busy along the chosen word
        ST_COMMIT: begin
          col_q <= col_q + 1'b1;
          if (col_last) begin
            state_q         <= ST_IDLE;
            done_q          <= 1'b1;
            rsp_q.granted   <= 1'b1;
            rsp_q.path_word <= word_q;
          end
        end

        // free switches along the given word
        ST_RELEASE: begin
          col_q <= col_q + 1'b1;
          if (col_last) begin
            state_q         <= ST_IDLE;
            done_q          <= 1'b1;
            rsp_q.granted   <= 1'b1;
            rsp_q.path_word <= '0;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // the scan only reads, write-back phases only write
  a_no_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !ram_we)
    else $error("switch table written during scan");

  a_read_only_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (state_q == ST_SCAN))
    else $error("switch table read outside scan");

  // a blocked route carries no path word
  a_blocked_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.granted) |-> (rsp_o.path_word == '0))
    else $error("blocked result with nonzero path word");

  // an accepted beat either works on or answers at once
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted request dropped");

  // no result while the table is still being cleared
  a_no_done_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !done_o)
    else $error("result during clearing sweep");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the omega network path allocator
// ----------------------------------------------------------------------------
// a scoreboard keeps its own switch table and network geometry, works out the
// grant or block of every accepted request beat and compares it with the
// result beats, field by field. a short directed part covers extreme ports,
// clamped and zero stage counts, the no-column network, overlapping port
// fields and releases of free switches. random traffic then runs three
// sender idle profiles (12 %, 48 %, none) over many geometries, mostly routes
// plus releases of paths that are still live, with some noise
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NumCells    = onpa_pkg::PortsDef * onpa_pkg::MaxColumnsDef;
  localparam int unsigned ItemsPerGeo = 55;
  localparam int unsigned GeosPerPass = 10;
  // longest route: 6 columns x 16 candidates plus write back, with margin
  localparam int unsigned TailCycles  = 150;
  localparam int unsigned MaxLivePaths = 48;
  localparam int unsigned MaxPrinted  = 40;
  // index with no register behind it, the block must ignore it
  localparam logic [onpa_pkg::CfgIdxW-1:0] CfgUnmapped = 2'd3;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          start_i    = 1'b0;
  logic                          busy_o;
  onpa_pkg::req_t                req_i      = '0;
  logic                          done_o;
  onpa_pkg::rsp_t                rsp_o;
  logic                          cfg_we_i   = 1'b0;
  logic [onpa_pkg::CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [onpa_pkg::CfgDataW-1:0] cfg_data_i = '0;

  omega_network_path_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // scoreboard state: switch table and register shadows
  // --------------------------------------------------------------------------
  bit                           sw_busy [NumCells];
  bit [1:0]                     sw_set  [NumCells];
  logic [onpa_pkg::StagesW-1:0] geo_stages = 3'd4;
  logic [onpa_pkg::ExtraW-1:0]  geo_extra  = 2'd0;
  logic [onpa_pkg::PortW-1:0]   geo_mask   = 8'hFF;

  onpa_pkg::req_t             request_q[$];      // request beats waiting for the driver
  onpa_pkg::rsp_t             circuit_rsp_q[$];  // predicted grants, oldest first
  logic [onpa_pkg::WordW-1:0] live_paths[$];     // granted words not yet released
  logic [onpa_pkg::WordW-1:0] last_grant = '0;
  int unsigned      idle_pct = 12;
  bit               drain_hold = 1'b0;
  int unsigned      beats_sent = 0;
  int unsigned      results_seen = 0;
  int unsigned      mismatch_cnt = 0;

  // stage counts above the supported range saturate, zero stays zero
  function automatic int unsigned base_stage_count();
    return (geo_stages > 3'd4) ? 4 : int'(geo_stages);
  endfunction

  function automatic int unsigned extra_stage_count();
    return (geo_extra > 2'd2) ? 2 : int'(geo_extra);
  endfunction

  // switch of column j: an 8-bit window of the word under the port mask
  function automatic int unsigned cell_index(logic [onpa_pkg::WordW-1:0] w, int unsigned s,
                                             int unsigned e, int unsigned j);
    logic [onpa_pkg::WordW-1:0] win;
    win = w >> (2 * (s + e) - 2 * (j + 1));
    return int'(win[onpa_pkg::PortW-1:0] & geo_mask) * onpa_pkg::MaxColumnsDef + j;
  endfunction

  function automatic logic [1:0] column_setting(logic [onpa_pkg::WordW-1:0] w,
                                                int unsigned s, int unsigned e,
                                                int unsigned j);
    logic [onpa_pkg::WordW-1:0] win;
    win = w >> (2 * (2 * s + e - 1) - 2 * j);
    return win[1:0];
  endfunction

  // grant or block for one request beat, updating the switch table
  function automatic onpa_pkg::rsp_t resolve_circuit(onpa_pkg::req_t rq);
    int unsigned                s;
    int unsigned                e;
    int unsigned                ncol;
    int unsigned                tries;
    int unsigned                c;
    logic [31:0]                cand;
    logic [onpa_pkg::WordW-1:0] w;
    bit                         clash;
    onpa_pkg::rsp_t             r;
    s     = base_stage_count();
    e     = extra_stage_count();
    ncol  = s + e;
    r     = '0;
    if (rq.func == onpa_pkg::FUNC_RELEASE) begin
      // clearing a switch that is already free changes nothing
      for (int unsigned j = 0; j < ncol && j < onpa_pkg::MaxColumnsDef; j++) begin
        c = cell_index(rq.release_word, s, e, j);
        sw_busy[c] = 1'b0;
        sw_set[c]  = 2'd0;
      end
      r.granted = 1'b1;
      return r;
    end
    tries = 1 << (2 * e);
    for (int unsigned x = 0; x < tries && !r.granted; x++) begin
      // port fields may overlap the extra digits on small networks: ORed in
      cand  = 32'(rq.dest_port) | (32'(rq.source_port) << (2 * s + 2 * e)) |
              (32'(x) << (2 * s));
      w     = cand[onpa_pkg::WordW-1:0];
      clash = 1'b0;
      // a busy switch may be shared if its setting is the same
      for (int unsigned j = 0; j < ncol && j < onpa_pkg::MaxColumnsDef; j++) begin
        c = cell_index(w, s, e, j);
        if (sw_busy[c] && sw_set[c] != column_setting(w, s, e, j)) clash = 1'b1;
      end
      if (!clash) begin
        for (int unsigned j = 0; j < ncol && j < onpa_pkg::MaxColumnsDef; j++) begin
          c = cell_index(w, s, e, j);
          sw_busy[c] = 1'b1;
          sw_set[c]  = column_setting(w, s, e, j);
        end
        r.granted   = 1'b1;
        r.path_word = w;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted) $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // driver: a beat is taken on an edge with start high and busy low; start is
  // re-decided every cycle so idle gaps land at any point of the block's work
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive
    onpa_pkg::rsp_t grant;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        grant = resolve_circuit(req_i);
        circuit_rsp_q = {circuit_rsp_q, grant};
        beats_sent++;
        // keep a pool of live words so releases hit real circuits
        if (req_i.func == onpa_pkg::FUNC_ROUTE && grant.granted) begin
          last_grant = grant.path_word;
          live_paths = {live_paths, grant.path_word};
          if (live_paths.size() > MaxLivePaths) void'(live_paths.pop_front());
        end else if (req_i.func == onpa_pkg::FUNC_RELEASE) begin
          for (int i = 0; i < live_paths.size(); i++) begin
            if (live_paths[i] == req_i.release_word) begin
              live_paths.delete(i);
              break;
            end
          end
        end
        void'(request_q.pop_front());
        // now and then hold back until every pending result is back
        if (beats_sent == 40 || $urandom_range(149) == 0) drain_hold = 1'b1;
      end
      if (drain_hold && circuit_rsp_q.size() == 0) drain_hold = 1'b0;
      if (!drain_hold && request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start_i <= 1'b1;
        req_i   <= request_q[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: a result beat lives for one cycle only, check it at its edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : observe
    onpa_pkg::rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_seen++;
      if (circuit_rsp_q.size() == 0) begin
        report_mismatch($sformatf("no result pending, got granted %0b word %05h",
                                  rsp_o.granted, rsp_o.path_word));
      end else begin
        want = circuit_rsp_q.pop_front();
        if (rsp_o.granted !== want.granted)
          report_mismatch($sformatf("granted %0b, predicted %0b",
                                    rsp_o.granted, want.granted));
        if (rsp_o.path_word !== want.path_word)
          report_mismatch($sformatf("path word %05h, predicted %05h",
                                    rsp_o.path_word, want.path_word));
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  // nothing queued, nothing outstanding and the block idle
  task automatic wait_quiet();
    while (request_q.size() != 0 || circuit_rsp_q.size() != 0 || busy_o !== 1'b0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [onpa_pkg::CfgIdxW-1:0] idx,
                           input logic [onpa_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      onpa_pkg::CFG_STAGES:    geo_stages = data[onpa_pkg::StagesW-1:0];
      onpa_pkg::CFG_EXTRA:     geo_extra  = data[onpa_pkg::ExtraW-1:0];
      onpa_pkg::CFG_PORT_MASK: geo_mask   = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // unused upper data bits are random, the registers must drop them
  task automatic set_geometry(input logic [2:0] s, input logic [1:0] e,
                              input logic [7:0] mask);
    wait_quiet();
    write_reg(onpa_pkg::CFG_STAGES, {5'($urandom_range(31)), s});
    write_reg(onpa_pkg::CFG_EXTRA, {6'($urandom_range(63)), e});
    write_reg(onpa_pkg::CFG_PORT_MASK, mask);
    live_paths.delete();
  endtask

  task automatic push_req(input onpa_pkg::req_t rq);
    while (request_q.size() > 1) @(posedge clk_i);
    request_q = {request_q, rq};
  endtask

  task automatic queue_route(input logic [onpa_pkg::PortW-1:0] src,
                             input logic [onpa_pkg::PortW-1:0] dst);
    onpa_pkg::req_t rq;
    rq.func         = onpa_pkg::FUNC_ROUTE;
    rq.source_port  = src;
    rq.dest_port    = dst;
    rq.release_word = onpa_pkg::WordW'($urandom);
    push_req(rq);
  endtask

  task automatic queue_release(input logic [onpa_pkg::WordW-1:0] w);
    onpa_pkg::req_t rq;
    rq.func         = onpa_pkg::FUNC_RELEASE;
    rq.source_port  = onpa_pkg::PortW'($urandom);
    rq.dest_port    = onpa_pkg::PortW'($urandom);
    rq.release_word = w;
    push_req(rq);
  endtask

  initial begin : stimulus
    int unsigned r;
    int unsigned seff;
    int unsigned span;
    logic [2:0]  s_val;
    logic [1:0]  e_val;
    logic [7:0]  m_val;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full size network, one column per base stage
    set_geometry(3'd4, 2'd0, 8'hFF);
    write_reg(CfgUnmapped, 8'($urandom));
    queue_route(8'h00, 8'h00);
    queue_route(8'hFF, 8'hFF);
    queue_route(8'hAA, 8'h55);
    wait_quiet();
    queue_release(last_grant);
    queue_release(last_grant);          // switches already free
    queue_release(20'hFFFFF);
    queue_route(8'h55, 8'hAA);

    // widest network: six columns, sixteen candidate words
    set_geometry(3'd4, 2'd2, 8'hFF);
    queue_route(8'h00, 8'hFF);
    queue_route(8'h40, 8'hFF);
    queue_route(8'h80, 8'hFF);
    queue_route(8'hC0, 8'hFF);

    // stage counts above range saturate
    set_geometry(3'd7, 2'd3, 8'hF0);
    queue_route(8'h12, 8'h34);
    queue_route(8'hFF, 8'h00);

    // no columns at all: granted at once, no switch touched
    set_geometry(3'd0, 2'd0, 8'h00);
    queue_route(8'h81, 8'h18);
    queue_release(20'hFFFFF);

    // extra stages only
    set_geometry(3'd0, 2'd2, 8'h03);
    queue_route(8'h03, 8'h00);
    queue_route(8'h00, 8'h03);

    // four ports: wide port values overlap the other digits
    set_geometry(3'd1, 2'd0, 8'h03);
    queue_route(8'hFF, 8'hFF);
    queue_route(8'h01, 8'h02);
    queue_route(8'h02, 8'h01);
    queue_route(8'h03, 8'h03);
    queue_route(8'h00, 8'h00);

    // random traffic, one pass per sender idle profile
    for (int pass = 0; pass < 3; pass++) begin
      for (int g = 0; g < GeosPerPass; g++) begin
        case (g)
          0: begin
            s_val = 3'd1; e_val = 2'd0; m_val = 8'h03;
          end
          1: begin
            s_val = 3'd4; e_val = 2'd2; m_val = 8'hFF;
          end
          default: begin
            r = $urandom_range(99);
            if (r < 45)      s_val = 3'($urandom_range(2, 1));
            else if (r < 80) s_val = 3'($urandom_range(4, 3));
            else if (r < 85) s_val = 3'd0;
            else             s_val = 3'($urandom_range(7, 5));
            e_val = 2'($urandom_range(3));
            seff  = (s_val > 3'd4) ? 4 : int'(s_val);
            r     = $urandom_range(99);
            if (r < 60)      m_val = (seff >= 4) ? 8'hFF : 8'((1 << (2 * seff)) - 1);
            else if (r < 85) m_val = 8'hFF;
            else             m_val = 8'($urandom);
          end
        endcase
        set_geometry(s_val, e_val, m_val);
        idle_pct = (pass == 0) ? 12 : (pass == 1) ? 48 : 0;
        seff = base_stage_count();
        span = (seff >= 4) ? onpa_pkg::PortsDef : (1 << (2 * seff));
        for (int n = 0; n < ItemsPerGeo; n++) begin
          r = $urandom_range(99);
          if (r < 55 || live_paths.size() == 0) begin
            // mostly ports that exist, sometimes full 8-bit values
            if ($urandom_range(9) == 0)
              queue_route(onpa_pkg::PortW'($urandom), onpa_pkg::PortW'($urandom));
            else
              queue_route(onpa_pkg::PortW'($urandom_range(span - 1)),
                          onpa_pkg::PortW'($urandom_range(span - 1)));
          end else if (r < 93) begin
            queue_release(live_paths[$urandom_range(live_paths.size() - 1)]);
          end else begin
            queue_release(onpa_pkg::WordW'($urandom));
          end
        end
      end
    end

    wait_quiet();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && circuit_rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin : watchdog
    #12ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
